// ----- rtl/cpf_pkg.sv -----
// Shared types, constants and register map of the CRC-protected packet framer.
// No dependencies; every other file in rtl/ imports this package.
package cpf_pkg;

    localparam int SERIAL_BYTES = 12;
    localparam int HDR_LEN      = 9 + SERIAL_BYTES;
    localparam int HDR_IDX_W    = $clog2(HDR_LEN);

    localparam int SERIAL_OFS   = 4;
    localparam int VERSION_OFS  = SERIAL_OFS + SERIAL_BYTES;
    localparam int CMD_HI_OFS   = VERSION_OFS + 1;
    localparam int CMD_LO_OFS   = VERSION_OFS + 2;
    localparam int MODEL_OFS    = VERSION_OFS + 3;
    localparam int ID_OFS       = VERSION_OFS + 4;

    localparam logic [7:0]  START_MARK = 8'h24;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    localparam logic [1:0] REG_SERIAL_HIGH = 2'd0;
    localparam logic [1:0] REG_SERIAL_LOW  = 2'd1;
    localparam logic [1:0] REG_VERSION     = 2'd2;
    localparam logic [1:0] REG_MODEL       = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [7:0]  op_type;
        logic [15:0] command;
        logic [7:0]  packet_id;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        in_item_t item;
        logic     last;
    } q_entry_t;

    typedef struct packed {
        logic [63:0] serial_high;
        logic [31:0] serial_low;
        logic [7:0]  version;
        logic [7:0]  model;
    } cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR,
        BK_HCRC_HI,
        BK_HCRC_LO,
        BK_PCRC_HI,
        BK_PCRC_LO
    } bk_state_t;

endpackage

// ----- rtl/crc_protected_packet_framer_unit.sv -----
// CRC-protected packet framer, top level.
// Usage: configure the serial number, version and model over the APB port while
// the block is idle, then stream items on the s_ channel (valid/ready). A start
// item (mode 0) produces a header of 9 + SERIAL_BYTES bytes (21 by default)
// followed by its big-endian CRC-16/MODBUS: 23 result transfers. Each payload
// item (mode 1) of an open packet produces its byte; the last one of the packet
// also produces the big-endian payload CRC. Payload with no open packet is
// dropped; a new start abandons an unfinished packet.
// Path: with the back end idle, an accepted item is written into the queue, then
// its first result is loaded into the output register and presented on m_.
// Throughput: one result byte per cycle on m_ while m_ready is high, set by the
// single output serializer; payload streams at one item per cycle, a start
// item holds it for all 23 results; a 4-entry queue separates input and output.
// Reset (aresetn low, synchronous) clears the registers, the queue, the open
// packet state and the output valid flag. When m_ready is low the result is held
// in the output register and input keeps flowing until the queue is full.
// Depends on cpf_pkg, cpf_regs, cpf_front, cpf_queue and cpf_back.
module crc_protected_packet_framer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cpf_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cpf_pkg::out_item_t            m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [cpf_pkg::PDATA_W-1:0]   pwdata,
    output logic [cpf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import cpf_pkg::*;

    cfg_t     cfg;
    q_entry_t q_wdata;
    q_entry_t q_rdata;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    cpf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    cpf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    cpf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_rdata (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/cpf_regs.sv -----
// APB-style configuration registers of the packet framer.
// Depends on cpf_pkg for the register map and the cfg_t bundle.
module cpf_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [cpf_pkg::PDATA_W-1:0]   pwdata,
    output logic [cpf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output cpf_pkg::cfg_t                 cfg
);
    import cpf_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SERIAL_HIGH: cfg_reg.serial_high <= pwdata;
                REG_SERIAL_LOW:  cfg_reg.serial_low  <= pwdata[31:0];
                REG_VERSION:     cfg_reg.version     <= pwdata[7:0];
                REG_MODEL:       cfg_reg.model       <= pwdata[7:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SERIAL_HIGH: prdata = cfg_reg.serial_high;
            REG_SERIAL_LOW:  prdata = {32'h0, cfg_reg.serial_low};
            REG_VERSION:     prdata = {56'h0, cfg_reg.version};
            REG_MODEL:       prdata = {56'h0, cfg_reg.model};
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/cpf_front.sv -----
// Front end: accepts input transfers, tracks the open packet and classifies items.
// Depends on cpf_pkg; feeds cpf_queue.
module cpf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cpf_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output cpf_pkg::q_entry_t q_wdata
);
    import cpf_pkg::*;

    logic        open_reg;
    logic        open_next;
    logic [15:0] remain_reg;
    logic [15:0] remain_next;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        open_next     = open_reg;
        remain_next   = remain_reg;
        q_push        = 1'b0;
        q_wdata.item  = s_data;
        q_wdata.last  = 1'b0;
        if (accept) begin
            if (s_data.mode == MODE_START) begin
                q_push      = 1'b1;
                open_next   = (s_data.payload_length != 16'h0);
                remain_next = s_data.payload_length;
            end else if (open_reg) begin
                q_push       = 1'b1;
                q_wdata.last = (remain_reg == 16'h1);
                remain_next  = remain_reg - 16'h1;
                open_next    = (remain_reg != 16'h1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg   <= 1'b0;
            remain_reg <= 16'h0;
        end else begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ----- rtl/cpf_queue.sv -----
// Short command queue between front and back end of the packet framer.
// Depends on cpf_pkg for the entry type and depth.
module cpf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cpf_pkg::q_entry_t wdata,
    input  logic              pop,
    output cpf_pkg::q_entry_t rdata,
    output logic              full,
    output logic              empty
);
    import cpf_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/cpf_back.sv -----
// Back end: serializes headers, payload bytes and CRC-16/MODBUS trailers.
// Depends on cpf_pkg; drains cpf_queue into the registered result channel.
module cpf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  cpf_pkg::cfg_t      cfg,
    input  cpf_pkg::q_entry_t  q_rdata,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output cpf_pkg::out_item_t m_data
);
    import cpf_pkg::*;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] header_byte(input logic [HDR_IDX_W-1:0] idx,
                                               input in_item_t h, input cfg_t c);
        logic [HDR_IDX_W-1:0] sidx;
        logic [7:0]           b;
        sidx = idx - HDR_IDX_W'(SERIAL_OFS);
        b    = 8'h00;
        priority if (idx == HDR_IDX_W'(0)) begin
            b = START_MARK;
        end else if (idx == HDR_IDX_W'(1)) begin
            b = h.op_type;
        end else if (idx == HDR_IDX_W'(2)) begin
            b = h.payload_length[15:8];
        end else if (idx == HDR_IDX_W'(3)) begin
            b = h.payload_length[7:0];
        end else if (idx < HDR_IDX_W'(VERSION_OFS)) begin
            if (sidx < HDR_IDX_W'(8)) begin
                b = c.serial_high[8 * (7 - int'(sidx)) +: 8];
            end else begin
                b = c.serial_low[8 * (11 - int'(sidx)) +: 8];
            end
        end else if (idx == HDR_IDX_W'(VERSION_OFS)) begin
            b = c.version;
        end else if (idx == HDR_IDX_W'(CMD_HI_OFS)) begin
            b = h.command[15:8];
        end else if (idx == HDR_IDX_W'(CMD_LO_OFS)) begin
            b = h.command[7:0];
        end else if (idx == HDR_IDX_W'(MODEL_OFS)) begin
            b = c.model;
        end else if (idx == HDR_IDX_W'(ID_OFS)) begin
            b = h.packet_id;
        end else begin
            b = 8'h00;
        end
        return b;
    endfunction

    bk_state_t            state_reg;
    bk_state_t            state_next;
    logic [HDR_IDX_W-1:0] idx_reg;
    logic [HDR_IDX_W-1:0] idx_next;
    logic [15:0]          crc_reg;
    logic [15:0]          crc_next;
    in_item_t             hdr_reg;
    in_item_t             hdr_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    out_item_t            m_data_reg;
    out_item_t            m_data_next;
    logic                 advance;
    logic [7:0]           hbyte;

    assign advance = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign hbyte   = header_byte(idx_reg, hdr_reg, cfg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        hdr_next     = hdr_reg;
        q_pop        = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next          = 1'b1;
            m_data_next.last_byte = 1'b0;
            unique case (state_reg)
                BK_IDLE: begin
                    m_valid_next = !q_empty;
                    if (!q_empty) begin
                        q_pop = 1'b1;
                        if (q_rdata.item.mode == MODE_START) begin
                            hdr_next             = q_rdata.item;
                            m_data_next.out_byte = START_MARK;
                            crc_next             = crc_update(CRC_INIT, START_MARK);
                            idx_next             = HDR_IDX_W'(1);
                            state_next           = BK_HDR;
                        end else begin
                            m_data_next.out_byte = q_rdata.item.payload_byte;
                            crc_next = crc_update(crc_reg, q_rdata.item.payload_byte);
                            if (q_rdata.last) begin
                                state_next = BK_PCRC_HI;
                            end
                        end
                    end
                end
                BK_HDR: begin
                    m_data_next.out_byte = hbyte;
                    crc_next             = crc_update(crc_reg, hbyte);
                    idx_next             = idx_reg + HDR_IDX_W'(1);
                    if (idx_reg == HDR_IDX_W'(HDR_LEN - 1)) begin
                        state_next = BK_HCRC_HI;
                    end
                end
                BK_HCRC_HI: begin
                    m_data_next.out_byte = crc_reg[15:8];
                    state_next           = BK_HCRC_LO;
                end
                BK_HCRC_LO: begin
                    m_data_next.out_byte  = crc_reg[7:0];
                    m_data_next.last_byte = (hdr_reg.payload_length == 16'h0);
                    crc_next              = CRC_INIT;
                    state_next            = BK_IDLE;
                end
                BK_PCRC_HI: begin
                    m_data_next.out_byte = crc_reg[15:8];
                    state_next           = BK_PCRC_LO;
                end
                BK_PCRC_LO: begin
                    m_data_next.out_byte  = crc_reg[7:0];
                    m_data_next.last_byte = 1'b1;
                    crc_next              = CRC_INIT;
                    state_next            = BK_IDLE;
                end
                default: begin
                    m_valid_next = 1'b0;
                    state_next   = BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg    <= hdr_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- rtl/cpf_checker.sv -----
// Port-level checks of the packet framer, bound to the top level.
// Depends on cpf_pkg and crc_protected_packet_framer_unit.
module cpf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input cpf_pkg::out_item_t            m_data,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [cpf_pkg::PADDR_W-1:0]   paddr,
    input logic [cpf_pkg::PDATA_W-1:0]   pwdata,
    input logic [cpf_pkg::PDATA_W-1:0]   prdata
);
    import cpf_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before transfer");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_version_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && paddr[PADDR_W-1:PADDR_W-2] == REG_VERSION)
        ##1 (psel && !pwrite && paddr[PADDR_W-1:PADDR_W-2] == REG_VERSION)
        |-> prdata[7:0] == $past(pwdata[7:0]))
        else $error("version register readback mismatch");

endmodule

bind crc_protected_packet_framer_unit cpf_checker u_cpf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

// ----- sim/tb_crc_protected_packet_framer_unit.sv -----
// Testbench for crc_protected_packet_framer_unit: a directed table and random packets,
// checked byte for byte against a local framer model, with random stalls and APB writes.
// Depends on rtl/cpf_pkg.sv and the framer RTL.
module tb_crc_protected_packet_framer_unit;
    import cpf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int SETTLE      = 12;
    localparam int NO_CHECK    = -1;

    typedef struct {
        in_item_t   item;
        int         n_results;
        logic [7:0] first_byte;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [63:0] sh_serial_high;
    logic [31:0] sh_serial_low;
    logic [7:0]  sh_version;
    logic [7:0]  sh_model;
    logic [15:0] pay_crc;
    logic [15:0] pay_left;
    logic        pkt_open;

    out_item_t   framed_bytes[$];
    int          row_count_q[$];
    logic [7:0]  row_first_q[$];
    dir_row_t    dir_rows[18];

    int   errors;
    int   cycles;
    int   n_in;
    int   n_out;
    int   n_writes;
    int   framed_sent;
    int   gen_left;
    logic calm;

    crc_protected_packet_framer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH cycle %0d: %s", cycles, msg);
    endtask

    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic frame_item(input in_item_t it, output int n);
        logic [7:0]  hdr [HDR_LEN];
        logic [15:0] crc;
        n = 0;
        if (it.mode == MODE_START) begin
            hdr[0] = START_MARK;
            hdr[1] = it.op_type;
            hdr[2] = it.payload_length[15:8];
            hdr[3] = it.payload_length[7:0];
            for (int i = 0; i < SERIAL_BYTES; i++) begin
                hdr[SERIAL_OFS + i] = (i < 8) ? sh_serial_high[63 - 8 * i -: 8]
                                              : sh_serial_low[31 - 8 * (i - 8) -: 8];
            end
            hdr[VERSION_OFS] = sh_version;
            hdr[CMD_HI_OFS]  = it.command[15:8];
            hdr[CMD_LO_OFS]  = it.command[7:0];
            hdr[MODEL_OFS]   = sh_model;
            hdr[ID_OFS]      = it.packet_id;
            crc = CRC_INIT;
            for (int i = 0; i < HDR_LEN; i++) begin
                crc = crc16_step(crc, hdr[i]);
                framed_bytes.push_back('{out_byte: hdr[i], last_byte: 1'b0});
            end
            framed_bytes.push_back('{out_byte: crc[15:8], last_byte: 1'b0});
            framed_bytes.push_back('{out_byte: crc[7:0],
                                     last_byte: (it.payload_length == 16'd0)});
            n        = HDR_LEN + 2;
            pay_crc  = CRC_INIT;
            pay_left = it.payload_length;
            pkt_open = (it.payload_length != 16'd0);
        end else if (pkt_open) begin
            pay_crc  = crc16_step(pay_crc, it.payload_byte);
            pay_left = pay_left - 16'd1;
            framed_bytes.push_back('{out_byte: it.payload_byte, last_byte: 1'b0});
            n = 1;
            if (pay_left == 16'd0) begin
                framed_bytes.push_back('{out_byte: pay_crc[15:8], last_byte: 1'b0});
                framed_bytes.push_back('{out_byte: pay_crc[7:0], last_byte: 1'b1});
                n        = 3;
                pkt_open = 1'b0;
                pay_crc  = CRC_INIT;
            end
        end
    endtask

    function automatic in_item_t random_item();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return in_item_t'(bits[$bits(in_item_t)-1:0]);
    endfunction

    function automatic in_item_t start_item(logic [7:0] op, logic [15:0] cmd,
                                            logic [7:0] id, logic [15:0] len);
        in_item_t it;
        it                = '0;
        it.mode           = MODE_START;
        it.op_type        = op;
        it.command        = cmd;
        it.packet_id      = id;
        it.payload_length = len;
        return it;
    endfunction

    function automatic in_item_t payload_item(logic [7:0] b);
        in_item_t it;
        it              = '0;
        it.mode         = MODE_PAYLOAD;
        it.payload_byte = b;
        return it;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge aclk) begin : track
        int         n;
        int         want_n;
        logic [7:0] want_first;
        out_item_t  want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                n_in++;
                frame_item(s_data, n);
                if (row_count_q.size() > 0) begin
                    want_n     = row_count_q.pop_front();
                    want_first = row_first_q.pop_front();
                    if (want_n != NO_CHECK && (n != want_n || (n > 0 &&
                        framed_bytes[framed_bytes.size() - n].out_byte != want_first))) begin
                        report_mismatch($sformatf("table row: %0d results, wanted %0d",
                                                  n, want_n));
                    end
                end
            end
            if (m_valid && m_ready) begin
                n_out++;
                if (framed_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer byte %02h last %0b",
                                              m_data.out_byte, m_data.last_byte));
                end else begin
                    want = framed_bytes.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_data.out_byte, want.out_byte));
                    end
                    if (m_data.last_byte !== want.last_byte) begin
                        report_mismatch($sformatf("last_byte %0b, expected %0b",
                                                  m_data.last_byte, want.last_byte));
                    end
                end
            end
        end
    end

    task automatic send(input in_item_t it, input int want_n, input logic [7:0] want_first);
        while (!calm && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        if (it.mode == MODE_START) begin
            gen_left = int'(it.payload_length);
            framed_sent++;
        end else if (gen_left > 0) begin
            gen_left--;
            framed_sent++;
        end
        row_count_q.push_back(want_n);
        row_first_q.push_back(want_first);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (framed_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (framed_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      framed_bytes.size()));
            framed_bytes.delete();
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_SERIAL_HIGH: sh_serial_high = value;
            REG_SERIAL_LOW:  sh_serial_low  = value[31:0];
            REG_VERSION:     sh_version     = value[7:0];
            REG_MODEL:       sh_model       = value[7:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_regs();
        logic [63:0] v;
        apb_read(REG_SERIAL_HIGH, v);
        if (v !== sh_serial_high) report_mismatch($sformatf("serial_high reads %h", v));
        apb_read(REG_SERIAL_LOW, v);
        if (v[31:0] !== sh_serial_low) report_mismatch($sformatf("serial_low reads %h", v));
        apb_read(REG_VERSION, v);
        if (v[7:0] !== sh_version) report_mismatch($sformatf("version reads %h", v));
        apb_read(REG_MODEL, v);
        if (v[7:0] !== sh_model) report_mismatch($sformatf("model reads %h", v));
    endtask

    task automatic set_config(input logic [63:0] hi, input logic [31:0] lo,
                              input logic [7:0] ver, input logic [7:0] model);
        apb_write(REG_SERIAL_HIGH, hi);
        apb_write(REG_SERIAL_LOW, {32'd0, lo});
        apb_write(REG_VERSION, {56'd0, ver});
        apb_write(REG_MODEL, {56'd0, model});
        check_regs();
    endtask

    task automatic random_phase(input int target);
        int       base;
        int       r;
        int       len;
        int       k;
        in_item_t it;
        base = framed_sent;
        while (framed_sent - base < target) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                if (r < 70) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                       : $urandom_range(0, 6);
                    k   = len;
                end else begin
                    len = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                               : $urandom_range(2, 8);
                    k   = (len > 1) ? $urandom_range(0, (len - 1 < 5) ? len - 1 : 5) : 0;
                end
                it                = random_item();
                it.mode           = MODE_START;
                it.payload_length = len[15:0];
                send(it, NO_CHECK, 8'h00);
                repeat (k) begin
                    it      = random_item();
                    it.mode = MODE_PAYLOAD;
                    send(it, NO_CHECK, 8'h00);
                end
            end else begin
                it      = random_item();
                it.mode = MODE_PAYLOAD;
                send(it, NO_CHECK, 8'h00);
            end
        end
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sh_serial_high = '0;
        sh_serial_low  = '0;
        sh_version     = '0;
        sh_model       = '0;
        pay_crc        = CRC_INIT;
        pay_left       = '0;
        pkt_open       = 1'b0;
        errors         = 0;
        cycles         = 0;
        n_in           = 0;
        n_out          = 0;
        n_writes       = 0;
        framed_sent    = 0;
        gen_left       = 0;
        calm           = 1'b0;

        dir_rows = '{
            '{payload_item(8'h3C), 0, 8'h00},
            '{start_item(8'h00, 16'h0000, 8'h00, 16'h0000), 23, START_MARK},
            '{start_item(8'hFF, 16'hFFFF, 8'hFF, 16'h0001), 23, START_MARK},
            '{payload_item(8'hFF), 3, 8'hFF},
            '{payload_item(8'h00), 0, 8'h00},
            '{start_item(8'h41, 16'h8001, 8'h5A, 16'h0003), NO_CHECK, 8'h00},
            '{payload_item(8'h00), 1, 8'h00},
            '{payload_item(8'hA5), 1, 8'hA5},
            '{payload_item(8'h5A), 3, 8'h5A},
            '{start_item(8'h7F, 16'h1234, 8'h80, 16'hFFFF), 23, START_MARK},
            '{payload_item(8'h01), 1, 8'h01},
            '{start_item(8'h80, 16'h7FFE, 8'h01, 16'h0002), 23, START_MARK},
            '{payload_item(8'h80), 1, 8'h80},
            '{payload_item(8'h7F), 3, 8'h7F},
            '{start_item(8'h24, 16'h00FF, 8'h7F, 16'h8000), 23, START_MARK},
            '{start_item(8'h01, 16'hFF00, 8'hFE, 16'h00FF), NO_CHECK, 8'h00},
            '{start_item(8'h2A, 16'h5555, 8'hAA, 16'h0000), 23, START_MARK},
            '{payload_item(8'h33), 0, 8'h00}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_regs();

        foreach (dir_rows[i]) begin
            send(dir_rows[i].item, dir_rows[i].n_results, dir_rows[i].first_byte);
        end
        drain();

        set_config('1, '1, 8'hFF, 8'hFF);
        random_phase(20);
        drain();

        set_config({$urandom(), $urandom()}, $urandom(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        calm = 1'b1;
        random_phase(20);
        drain();
        calm = 1'b0;

        set_config(64'hA55A_0FF0_3CC3_9669, 32'h5AA5_F00F, 8'hA5, 8'h5A);
        random_phase(20);
        drain();

        set_config('0, '0, 8'h00, 8'h00);
        random_phase(20);
        drain();

        $display("covered %0d input transfers and %0d result transfers",
                 n_in, n_out);
        $display("across %0d register writes, with zero-length, abandoned and stray-payload",
                 n_writes);
        $display("packets under random stalls");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
